>>> hw/rtl/tcbcr_pkg.sv
// Shared types and constants for the text card bus and cell renderer.
// Used by the top level; the generic RAM stands alone.
package tcbcr_pkg;

   localparam int VRAM_BYTES_DEF = 4096;
   localparam int FONT_BYTES     = 4096;
   localparam int FONT_AW        = $clog2(FONT_BYTES);

   typedef enum logic [2:0] {
      OP_CTRL_RD = 3'd0,
      OP_CTRL_WR = 3'd1,
      OP_WIN_RD  = 3'd2,
      OP_WIN_WR  = 3'd3,
      OP_RENDER  = 3'd4,
      OP_SYNC    = 3'd5,
      OP_FONT    = 3'd6
   } op_type;

   // control window offsets
   localparam logic [3:0] REG_CRTC_ADDR = 4'd0;
   localparam logic [3:0] REG_CRTC_DATA = 4'd1;
   localparam logic [3:0] REG_CTRL_ONE  = 4'd2;
   localparam logic [3:0] REG_CTRL_TWO  = 4'd3;

   localparam logic [1:0] SRC_INTERNAL = 2'd0;
   localparam logic [1:0] SRC_ROM      = 2'd1;
   localparam logic [1:0] SRC_CRTC     = 2'd2;

   localparam logic [1:0] STROBE_NONE = 2'd0;
   localparam logic [1:0] STROBE_ADDR = 2'd1;
   localparam logic [1:0] STROBE_DATA = 2'd2;

   localparam logic [11:0] WINDOW_RAM_BASE = 12'h400;
   localparam logic [11:0] ROM_OFFSET      = 12'h800;
   localparam logic [7:0]  UNMAPPED_BYTE   = 8'hFF;
   localparam logic [7:0]  SOLID_ROW       = 8'hFF;

   // control_one bits
   localparam int C1_ROMSEL   = 7;
   localparam int C1_PAGEMODE = 4;
   // control_two bits
   localparam int C2_DIPS    = 7;
   localparam int C2_INV_SET = 5;
   localparam int C2_HL_SET  = 4;
   localparam int C2_INV_CLR = 1;
   localparam int C2_HL_CLR  = 0;

   localparam logic [1:0] GREY_BLACK = 2'd0;
   localparam logic [1:0] GREY_LOW   = 2'd1;
   localparam logic [1:0] GREY_DIP   = 2'd2;
   localparam logic [1:0] GREY_HIGH  = 2'd3;

   typedef struct packed {
      logic        render;
      logic        ram_rd;
      logic [7:0]  rd;
      logic [1:0]  src;
      logic [11:0] rom;
      logic [1:0]  strobe;
      logic [7:0]  cdata;
      logic [3:0]  row;
      logic        solid;
      logic [7:0]  c2;
   } s1_type;

   typedef struct packed {
      logic        render;
      logic [7:0]  rd;
      logic [1:0]  src;
      logic [11:0] rom;
      logic [1:0]  strobe;
      logic [7:0]  cdata;
      logic        solid;
      logic [1:0]  fg;
      logic [1:0]  bg;
   } s2_type;

   typedef struct packed {
      logic [7:0]  rd;
      logic [1:0]  src;
      logic [11:0] rom;
      logic [1:0]  strobe;
      logic [7:0]  cdata;
      logic [15:0] pixels;
   } rsp_type;

endpackage

>>> hw/rtl/tcbcr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old word on a same-cycle write. No dependencies.
module tcbcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/text_card_bus_and_cell_render.sv
// Text card bus side and one-cell renderer, top level.
// Depends on tcbcr_pkg and tcbcr_ram (video RAM and font store).
// Three register stages (s1, s2, rsp); rsp_valid rises when a word loads into the
// response register. Throughput: one word per cycle while neither rsp_stall nor the
// clearing pass stalls the flow; VRAM read at accept, font read one stage later.
// Reset: control registers, frame count and pipeline valids clear at once;
// then a clearing pass zeroes every video RAM byte in turn with req_stall high.
module text_card_bus_and_cell_render #(
   parameter int VRAM_BYTES = tcbcr_pkg::VRAM_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [3:0]  req_glyph_row,
   input  logic        req_cursor_here,
   input  logic        req_sync_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_data_source,
   output logic [11:0] rsp_rom_address,
   output logic [1:0]  rsp_crtc_strobe,
   output logic [7:0]  rsp_crtc_write_data,
   output logic [15:0] rsp_pixels
);

   localparam int VRAM_AW = $clog2(VRAM_BYTES);

   tcbcr_pkg::op_type op;
   logic [3:0]  off;
   logic        req_accept;

   logic [7:0]  control_one_ff, control_one_in;
   logic [7:0]  control_two_ff, control_two_in;
   logic [11:0] bank_base_ff, bank_base_in;
   logic [3:0]  frame_count_ff, frame_count_in;
   logic        clearing_ff, clearing_in;
   logic [VRAM_AW-1:0] clr_ptr_ff, clr_ptr_in;

   tcbcr_pkg::s1_type  s1_ff, s1_in, s1_new;
   tcbcr_pkg::s2_type  s2_ff, s2_in, s2_new;
   tcbcr_pkg::rsp_type rsp_ff, rsp_in, rsp_new;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ready_c, s2_ready, s1_ready, s2_load, rsp_load;

   logic               win_rd_hit, win_wr_hit;
   logic [VRAM_AW-1:0] win_idx, cell_idx;
   logic               vram_we, vram_re;
   logic [VRAM_AW-1:0] vram_waddr, vram_raddr;
   logic [7:0]         vram_wdata, vram_rdata;
   logic               font_we, font_re;
   logic [7:0]         font_rdata;

   logic        hi, light, inv;
   logic [1:0]  fg0;
   logic [7:0]  glyph;
   logic [15:0] px;

   // reduce a sum below 4*VRAM_BYTES into the VRAM range by repeated compare-subtract
   function automatic logic [VRAM_AW-1:0] wrap_index(input logic [12:0] v);
      logic [12:0] t;
      t = v;
      for (int i = 0; i < 3; i++) begin
         if (t >= 13'(VRAM_BYTES)) begin
            t = t - 13'(VRAM_BYTES);
         end
      end
      return t[VRAM_AW-1:0];
   endfunction

   assign op         = tcbcr_pkg::op_type'(req_op);
   assign off        = req_address[3:0];
   assign req_accept = req_valid && !req_stall;

   // ready chain through the three stages
   assign rsp_ready_c = !rsp_valid_ff || !rsp_stall;
   assign s2_ready    = !s2_valid_ff || rsp_ready_c;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign req_stall   = clearing_ff || !s1_ready;
   assign s2_load     = s1_valid_ff && s2_ready;
   assign rsp_load    = s2_valid_ff && rsp_ready_c;

   assign win_idx  = wrap_index(13'({1'b0, req_address}) - 13'(tcbcr_pkg::WINDOW_RAM_BASE)
                                + 13'({1'b0, bank_base_ff}));
   assign cell_idx = wrap_index(13'({1'b0, req_address}));

   // accept stage: control state update and bus-side result fields
   always_comb begin
      control_one_in = control_one_ff;
      control_two_in = control_two_ff;
      bank_base_in   = bank_base_ff;
      frame_count_in = frame_count_ff;
      win_rd_hit     = 1'b0;
      win_wr_hit     = 1'b0;
      font_we        = 1'b0;
      s1_new         = '0;
      s1_new.src     = tcbcr_pkg::SRC_INTERNAL;
      s1_new.strobe  = tcbcr_pkg::STROBE_NONE;
      s1_new.row     = req_glyph_row;
      s1_new.solid   = req_cursor_here && frame_count_ff[3];
      s1_new.c2      = control_two_ff;
      case (op)
         tcbcr_pkg::OP_CTRL_RD: begin
            case (off)
               tcbcr_pkg::REG_CRTC_DATA: s1_new.src = tcbcr_pkg::SRC_CRTC;
               tcbcr_pkg::REG_CTRL_ONE:  s1_new.rd  = control_one_ff;
               tcbcr_pkg::REG_CTRL_TWO:  s1_new.rd  = control_two_ff;
               default:                  s1_new.rd  = tcbcr_pkg::UNMAPPED_BYTE;
            endcase
            if (!control_one_ff[tcbcr_pkg::C1_PAGEMODE]) begin
               bank_base_in = {1'b0, off[3:2], 9'b0};
            end
         end
         tcbcr_pkg::OP_CTRL_WR: begin
            case (off)
               tcbcr_pkg::REG_CRTC_ADDR: begin
                  s1_new.strobe = tcbcr_pkg::STROBE_ADDR;
                  s1_new.cdata  = req_data;
               end
               tcbcr_pkg::REG_CRTC_DATA: begin
                  s1_new.strobe = tcbcr_pkg::STROBE_DATA;
                  s1_new.cdata  = req_data;
               end
               tcbcr_pkg::REG_CTRL_ONE: begin
                  control_one_in = req_data;
                  if (req_data[tcbcr_pkg::C1_PAGEMODE]) begin
                     bank_base_in = {req_data[3:0], 8'b0};
                  end
               end
               tcbcr_pkg::REG_CTRL_TWO: control_two_in = req_data;
               default: ;
            endcase
            // block mode follows the offset, using control_one after the write
            if (!control_one_in[tcbcr_pkg::C1_PAGEMODE]) begin
               bank_base_in = {1'b0, off[3:2], 9'b0};
            end
         end
         tcbcr_pkg::OP_WIN_RD: begin
            if (req_address < tcbcr_pkg::WINDOW_RAM_BASE ||
                control_one_ff[tcbcr_pkg::C1_ROMSEL]) begin
               s1_new.src = tcbcr_pkg::SRC_ROM;
               s1_new.rom = req_address + tcbcr_pkg::ROM_OFFSET;
            end else begin
               win_rd_hit    = 1'b1;
               s1_new.ram_rd = 1'b1;
            end
         end
         tcbcr_pkg::OP_WIN_WR: begin
            win_wr_hit = req_address >= tcbcr_pkg::WINDOW_RAM_BASE;
         end
         tcbcr_pkg::OP_RENDER: s1_new.render = 1'b1;
         tcbcr_pkg::OP_SYNC: begin
            if (req_sync_level) begin
               frame_count_in = frame_count_ff + 4'd1;
            end
         end
         tcbcr_pkg::OP_FONT: font_we = 1'b1;
         default: ;
      endcase
      if (!req_accept) begin
         control_one_in = control_one_ff;
         control_two_in = control_two_ff;
         bank_base_in   = bank_base_ff;
         frame_count_in = frame_count_ff;
         font_we        = 1'b0;
      end
   end

   // video RAM: cleared after reset, then written and read at accept
   assign vram_we    = clearing_ff || (req_accept && win_wr_hit);
   assign vram_waddr = clearing_ff ? clr_ptr_ff : win_idx;
   assign vram_wdata = clearing_ff ? 8'h00 : req_data;
   assign vram_re    = req_accept && (win_rd_hit || op == tcbcr_pkg::OP_RENDER);
   assign vram_raddr = (op == tcbcr_pkg::OP_RENDER) ? cell_idx : win_idx;

   assign clr_ptr_in  = clearing_ff ? clr_ptr_ff + VRAM_AW'(1) : clr_ptr_ff;
   assign clearing_in = clearing_ff && (clr_ptr_ff != VRAM_AW'(VRAM_BYTES - 1));

   tcbcr_ram #(
      .WIDTH(8),
      .DEPTH(VRAM_BYTES)
   ) u_vram (
      .clock(clock),
      .we   (vram_we),
      .waddr(vram_waddr),
      .wdata(vram_wdata),
      .re   (vram_re),
      .raddr(vram_raddr),
      .rdata(vram_rdata)
   );

   // font store: loaded at accept, read when a word leaves stage one
   assign font_re = s2_load;

   tcbcr_ram #(
      .WIDTH(8),
      .DEPTH(tcbcr_pkg::FONT_BYTES)
   ) u_font (
      .clock(clock),
      .we   (font_we),
      .waddr(req_address[tcbcr_pkg::FONT_AW-1:0]),
      .wdata(req_data),
      .re   (font_re),
      .raddr({vram_rdata, s1_ff.row}),
      .rdata(font_rdata)
   );

   // stage one: character byte is back, pick colors
   always_comb begin
      hi    = vram_rdata[7];
      light = hi ? s1_ff.c2[tcbcr_pkg::C2_HL_SET]  : s1_ff.c2[tcbcr_pkg::C2_HL_CLR];
      inv   = hi ? s1_ff.c2[tcbcr_pkg::C2_INV_SET] : s1_ff.c2[tcbcr_pkg::C2_INV_CLR];
      fg0   = light ? tcbcr_pkg::GREY_HIGH : tcbcr_pkg::GREY_LOW;
      s2_new.render = s1_ff.render;
      s2_new.rd     = s1_ff.ram_rd ? vram_rdata : s1_ff.rd;
      s2_new.src    = s1_ff.src;
      s2_new.rom    = s1_ff.rom;
      s2_new.strobe = s1_ff.strobe;
      s2_new.cdata  = s1_ff.cdata;
      s2_new.solid  = s1_ff.solid;
      if (s1_ff.c2[tcbcr_pkg::C2_DIPS]) begin
         s2_new.fg = tcbcr_pkg::GREY_DIP;
         s2_new.bg = tcbcr_pkg::GREY_BLACK;
      end else if (inv) begin
         s2_new.fg = tcbcr_pkg::GREY_BLACK;
         s2_new.bg = fg0;
      end else begin
         s2_new.fg = fg0;
         s2_new.bg = tcbcr_pkg::GREY_BLACK;
      end
   end

   // stage two: glyph row is back, expand to pixels
   always_comb begin
      glyph = s2_ff.solid ? tcbcr_pkg::SOLID_ROW : font_rdata;
      px    = '0;
      for (int b = 0; b < 8; b++) begin
         px[2*b +: 2] = glyph[b] ? s2_ff.fg : s2_ff.bg;
      end
      rsp_new.rd     = s2_ff.rd;
      rsp_new.src    = s2_ff.src;
      rsp_new.rom    = s2_ff.rom;
      rsp_new.strobe = s2_ff.strobe;
      rsp_new.cdata  = s2_ff.cdata;
      rsp_new.pixels = s2_ff.render ? px : 16'h0000;
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_ready);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !rsp_ready_c);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign s1_in        = req_accept ? s1_new : s1_ff;
   assign s2_in        = s2_load ? s2_new : s2_ff;
   assign rsp_in       = rsp_load ? rsp_new : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_one_ff <= '0;
         control_two_ff <= '0;
         bank_base_ff   <= '0;
         frame_count_ff <= '0;
         clearing_ff    <= 1'b1;
         clr_ptr_ff     <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         control_one_ff <= control_one_in;
         control_two_ff <= control_two_in;
         bank_base_ff   <= bank_base_in;
         frame_count_ff <= frame_count_in;
         clearing_ff    <= clearing_in;
         clr_ptr_ff     <= clr_ptr_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_ff.rd;
   assign rsp_data_source     = rsp_ff.src;
   assign rsp_rom_address     = rsp_ff.rom;
   assign rsp_crtc_strobe     = rsp_ff.strobe;
   assign rsp_crtc_write_data = rsp_ff.cdata;
   assign rsp_pixels          = rsp_ff.pixels;

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> req_stall)
      else $error("request taken during VRAM clearing pass");

   a_vram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(vram_re && (clearing_ff || (req_accept && win_wr_hit))))
      else $error("VRAM read and write issued together");

   a_frame_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !reset && !req_accept |=> $stable(frame_count_ff))
      else $error("frame count moved without an accepted word");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !rsp_ready_c |=> s2_valid_ff)
      else $error("stage two word dropped under stall");

   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("response register lost a loaded word");

endmodule
